### sv/kmst_pkg.sv
`timescale 1ns / 1ps
// kmst_pkg: shared types and constants for the kruskal union-find block
// no dependencies; imported by the controller, datapath and top level

package kmst_pkg;

    // fixed field widths
    localparam int ID_W   = 8;
    localparam int WGT_W  = 16;
    localparam int SUM_W  = 24;
    localparam int CNT_W  = 9;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [SUM_W-1:0] SUM_MAX       = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] NUM_NODES_RST = 9'd256;
    localparam logic [CNT_W-1:0] COUNT_RST     = 9'd1;

    // register index taken from paddr[2]
    localparam logic REG_NUM_NODES = 1'b0;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_WALK_A,
        S_WALK_B,
        S_MERGE,
        S_REPORT
    } t_state;

    // source of the next table read address
    typedef enum logic [1:0] {
        NODE_HOLD,
        NODE_A,
        NODE_B,
        NODE_UP
    } t_node_sel;

    // controller to datapath
    typedef struct packed {
        logic      load;
        t_node_sel node_sel;
        logic      save_ra;
        logic      merge;
        logic      report;
        logic      clear_step;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic tree_done;
        logic at_root;
        logic clr_last;
        logic last;
    } t_dp_sts;

endpackage

### sv/kmst_datapath.sv
`timescale 1ns / 1ps
// kmst_datapath: parent table memory, root walk pointer, weight sum, join count
// depends on kmst_pkg; driven by kmst_ctrl commands

module kmst_datapath #(
    parameter int MAX_NODES = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kmst_pkg::t_dp_cmd           i_cmd,
    output kmst_pkg::t_dp_sts           o_sts,
    input  logic [kmst_pkg::CNT_W-1:0]  i_num_nodes,
    input  logic [kmst_pkg::WGT_W-1:0]  i_edge_weight,
    input  logic [kmst_pkg::ID_W-1:0]   i_node_a,
    input  logic [kmst_pkg::ID_W-1:0]   i_node_b,
    input  logic                        i_last_edge,
    output logic                        o_done,
    output logic [kmst_pkg::SUM_W-1:0]  o_total_weight,
    output logic                        o_spanning
);
    import kmst_pkg::*;

    localparam int NW     = $clog2(MAX_NODES);
    localparam int ID_CNT = 1 << ID_W;

    // node id reduction table, constant per elaboration
    logic [NW-1:0] w_mod_tab [ID_CNT];
    for (genvar g = 0; g < ID_CNT; g++) begin : g_mod
        assign w_mod_tab[g] = NW'(g % MAX_NODES);
    end

    logic [NW-1:0]    r_mem [MAX_NODES];
    logic [NW-1:0]    r_rd;
    logic [NW-1:0]    r_node, n_node;
    logic [NW-1:0]    r_a, r_b, r_ra;
    logic [NW-1:0]    r_clr_idx;
    logic [WGT_W-1:0] r_w;
    logic             r_last;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;
    logic             r_done;
    logic [SUM_W-1:0] r_total;
    logic             r_span;

    logic             w_differ;
    logic             w_mem_we;
    logic [NW-1:0]    w_mem_addr;
    logic [NW-1:0]    w_mem_wd;
    logic [SUM_W:0]   w_sum_ext;
    logic [CNT_W-1:0] w_need;
    logic             w_tree_done;

    // walk pointer select
    always_comb begin
        unique case (i_cmd.node_sel)
            NODE_HOLD: n_node = r_node;
            NODE_A:    n_node = r_a;
            NODE_B:    n_node = r_b;
            NODE_UP:   n_node = r_rd;
            default:   n_node = r_node;
        endcase
    end

    // merge and clear both use the single table port
    assign w_differ   = (r_ra != r_node);
    assign w_mem_we   = i_cmd.clear_step | (i_cmd.merge & w_differ);
    assign w_mem_addr = i_cmd.clear_step ? r_clr_idx : r_node;
    assign w_mem_wd   = i_cmd.clear_step ? r_clr_idx : r_ra;

    // parent table, one port, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wd;
        end else begin
            r_rd <= r_mem[n_node];
        end
    end

    // saturating sum and completion check
    assign w_sum_ext   = {1'b0, r_sum} + (SUM_W + 1)'(r_w);
    assign w_need      = (i_num_nodes == '0) ? COUNT_RST : i_num_nodes;
    assign w_tree_done = (r_count >= w_need);

    // edge payload and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w    <= i_edge_weight;
            r_a    <= w_mod_tab[i_node_a];
            r_b    <= w_mod_tab[i_node_b];
            r_last <= i_last_edge;
        end
        r_node <= n_node;
        if (i_cmd.save_ra) begin
            r_ra <= r_node;
        end
        if (i_cmd.report) begin
            r_total <= r_sum;
            r_span  <= w_tree_done;
        end
    end

    // set state, clear sweep index and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_count   <= COUNT_RST;
            r_clr_idx <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.report;
            if (i_cmd.report) begin
                r_sum     <= '0;
                r_count   <= COUNT_RST;
                r_clr_idx <= '0;
            end else begin
                if (i_cmd.merge && w_differ) begin
                    r_sum   <= w_sum_ext[SUM_W] ? SUM_MAX : w_sum_ext[SUM_W-1:0];
                    r_count <= r_count + CNT_W'(1);
                end
                if (i_cmd.clear_step) begin
                    r_clr_idx <= r_clr_idx + NW'(1);
                end
            end
        end
    end

    assign o_sts.tree_done = w_tree_done;
    assign o_sts.at_root   = (r_rd == r_node);
    assign o_sts.clr_last  = (r_clr_idx == NW'(MAX_NODES - 1));
    assign o_sts.last      = r_last;

    assign o_done         = r_done;
    assign o_total_weight = r_total;
    assign o_spanning     = r_span;

    // a report always strobes the result and restarts the set state
    a_report_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.report |=> r_done)
        else $error("report not followed by result strobe");

    a_report_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.report |=> (r_sum == '0) && (r_count == COUNT_RST))
        else $error("set state not cleared after report");

    // a real merge bumps the count by exactly one
    a_merge_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.merge && w_differ && !i_cmd.report)
            |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("join count not advanced on merge");

endmodule

### sv/kmst_ctrl.sv
`timescale 1ns / 1ps
// kmst_ctrl: sequencer for clear sweep, two root walks, merge and report
// depends on kmst_pkg; drives kmst_datapath

module kmst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  kmst_pkg::t_dp_sts i_sts,
    output kmst_pkg::t_dp_cmd o_cmd
);
    import kmst_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.node_sel = NODE_HOLD;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.tree_done) begin
                    n_state = i_sts.last ? S_REPORT : S_IDLE;
                end else begin
                    o_cmd.node_sel = NODE_A;
                    n_state        = S_WALK_A;
                end
            end
            S_WALK_A: begin
                if (i_sts.at_root) begin
                    o_cmd.save_ra  = 1'b1;
                    o_cmd.node_sel = NODE_B;
                    n_state        = S_WALK_B;
                end else begin
                    o_cmd.node_sel = NODE_UP;
                end
            end
            S_WALK_B: begin
                if (i_sts.at_root) begin
                    n_state = S_MERGE;
                end else begin
                    o_cmd.node_sel = NODE_UP;
                end
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state     = i_sts.last ? S_REPORT : S_IDLE;
            end
            S_REPORT: begin
                o_cmd.report = 1'b1;
                n_state      = S_CLEAR;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    // a report is always followed by a full clear sweep
    a_report_then_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPORT) |=> (r_state == S_CLEAR))
        else $error("report not followed by clear sweep");

    // an accepted edge is always checked against completion first
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_CHECK))
        else $error("accepted edge skipped completion check");

    // table never written while idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(o_cmd.merge || o_cmd.clear_step))
        else $error("table written while idle");

endmodule

### sv/kruskal_union_find_mst.sv
`timescale 1ns / 1ps
// kruskal_union_find_mst: top level, apb register and controller/datapath hookup
// depends on kmst_pkg, kmst_ctrl and kmst_datapath
//
//  channel   | handshake                          | payload
//  ----------+------------------------------------+---------------------------------------
//  edge in   | start high while busy low          | i_edge_weight i_node_a i_node_b
//            |                                    | i_last_edge
//  result    | o_done strobe, one cycle           | o_total_weight o_spanning
//  config    | psel penable pwrite, pready high   | paddr pwdata prdata (num_nodes at 0)
//
// an edge walks up the tree from each endpoint to its root, one table read per
// walk step on the single parent-table port
// an edge that arrives once the tree is complete skips the walks and the merge
// the last edge adds a report state plus a clear sweep of all MAX_NODES table entries
// reset starts the same clear sweep, busy stays high meanwhile
// results cannot be stalled; config writes are taken at any time

module kruskal_union_find_mst #(
    parameter int MAX_NODES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [kmst_pkg::WGT_W-1:0]    i_edge_weight,
    input  logic [kmst_pkg::ID_W-1:0]     i_node_a,
    input  logic [kmst_pkg::ID_W-1:0]     i_node_b,
    input  logic                          i_last_edge,
    output logic                          o_done,
    output logic [kmst_pkg::SUM_W-1:0]    o_total_weight,
    output logic                          o_spanning,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kmst_pkg::ADDR_W-1:0]   paddr,
    input  logic [kmst_pkg::DATA_W-1:0]   pwdata,
    output logic [kmst_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import kmst_pkg::*;

    logic [CNT_W-1:0] r_num_nodes;
    logic             w_cfg_wr;
    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;

    // apb register write
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes <= NUM_NODES_RST;
        end else if (w_cfg_wr && (paddr[2] == REG_NUM_NODES)) begin
            r_num_nodes <= pwdata[CNT_W-1:0];
        end
    end

    // apb register read
    assign prdata = (paddr[2] == REG_NUM_NODES) ? DATA_W'(r_num_nodes) : '0;

    kmst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    kmst_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_num_nodes    (r_num_nodes),
        .i_edge_weight  (i_edge_weight),
        .i_node_a       (i_node_a),
        .i_node_b       (i_node_b),
        .i_last_edge    (i_last_edge),
        .o_done         (o_done),
        .o_total_weight (o_total_weight),
        .o_spanning     (o_spanning)
    );

endmodule
